[design/usvg_pkg.sv]
// Shared constants and the arctangent table for the UV sphere vertex generator.
package usvg_pkg;

  localparam int COORD_FRAC_BITS = 14;
  localparam int INDEX_BITS      = 8;
  localparam int CNT_W           = 8;
  localparam int ANG_W           = 32;
  localparam int REM_W           = CNT_W + 1;
  localparam int NUM_W           = INDEX_BITS + 34;
  localparam int ROT_STEPS       = 30;
  localparam int CW              = 33;
  localparam int ZW              = 32;
  localparam int PROD_W          = 2 * CW;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 8;

  localparam logic signed [CW-1:0] ROT_GAIN_INV = 33'sh026DD3B6A;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_COUNT = 8'd1;

  localparam logic [CNT_W-1:0] STACK_COUNT_RST = 8'd16;
  localparam logic [CNT_W-1:0] SLICE_COUNT_RST = 8'd16;

  // atan(2^-k) in 2^-32 turns
  function automatic logic signed [ZW-1:0] atan_turn(input int k);
    logic signed [ZW-1:0] v;
    unique case (k)
      0:  v = 32'sh20000000;
      1:  v = 32'sh12E4051E;
      2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;
      4:  v = 32'sh028B0D43;
      5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;
      7:  v = 32'sh00517C55;
      8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;
      10: v = 32'sh000A2F98;
      11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;
      13: v = 32'sh000145F3;
      14: v = 32'sh0000A2F9;
      15: v = 32'sh0000517C;
      16: v = 32'sh000028BE;
      17: v = 32'sh0000145F;
      18: v = 32'sh00000A2F;
      19: v = 32'sh00000517;
      20: v = 32'sh0000028B;
      21: v = 32'sh00000145;
      22: v = 32'sh000000A2;
      23: v = 32'sh00000051;
      24: v = 32'sh00000028;
      25: v = 32'sh00000014;
      26: v = 32'sh0000000A;
      27: v = 32'sh00000005;
      28: v = 32'sh00000002;
      29: v = 32'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/uv_sphere_vertex_generator_core.sv]
// UV sphere vertex generator: pipelined divider, CORDIC and product stages.
// Takes one grid point (stack_index, slice_index) per cycle and returns the unit-sphere
// vertex in signed Q1.14 after it passes through one entry stage, 42 stages of
// a bit-per-stage restoring divider that forms both angles, 30 CORDIC rotation stages,
// one quadrant stage, one multiply stage and the rounding output register. Throughput
// is one item per cycle; the whole pipeline holds while a result waits at the output.
// An index above its configured count gives out_of_range with zero coordinates, as does
// a count of zero. stack_count and slice_count (register 0 and 1) may be written only
// while no item is in flight.
module uv_sphere_vertex_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // stack_index, slice_index
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [47:0]                    m_tdata,   // pos_x, pos_y, pos_z
  output logic [0:0]                     m_tuser,   // out_of_range
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [usvg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [usvg_pkg::CNT_W-1:0]     cfg_data
);

  localparam int NW = usvg_pkg::NUM_W;
  localparam int RS = usvg_pkg::ROT_STEPS;
  localparam int CW = usvg_pkg::CW;
  localparam int ZW = usvg_pkg::ZW;
  localparam int PW = usvg_pkg::PROD_W;
  localparam int RW = usvg_pkg::REM_W;
  localparam int AW = usvg_pkg::ANG_W;
  localparam int FB = usvg_pkg::COORD_FRAC_BITS;
  localparam int SH_XZ = 60 - FB;
  localparam int SH_Y  = 30 - FB;

  logic [usvg_pkg::CNT_W-1:0] stack_count;
  logic [usvg_pkg::CNT_W-1:0] slice_count;
  logic                       advance;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= usvg_pkg::STACK_COUNT_RST;
      slice_count <= usvg_pkg::SLICE_COUNT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == usvg_pkg::CFG_STACK_COUNT) stack_count <= cfg_data;
      if (cfg_index == usvg_pkg::CFG_SLICE_COUNT) slice_count <= cfg_data;
    end
  end

  // entry stage and divider pipeline
  logic [usvg_pkg::INDEX_BITS-1:0] in_stack;
  logic [usvg_pkg::INDEX_BITS-1:0] in_slice;
  logic                            in_oor;
  logic [RW-1:0]                   dvs_pol;
  logic [RW-1:0]                   dvs_az;

  assign in_stack = s_tdata[7:0];
  assign in_slice = s_tdata[15:8];
  assign in_oor   = (stack_count == '0) || (slice_count == '0) ||
                    (in_stack > stack_count) || (in_slice > slice_count);
  assign dvs_pol  = {stack_count, 1'b0};
  assign dvs_az   = {slice_count, 1'b0};

  logic          v_d   [0:NW];
  logic          oor_d [0:NW];
  logic [RW-1:0] rem_p [0:NW];
  logic [NW-1:0] num_p [0:NW];
  logic [AW-1:0] quo_p [0:NW];
  logic [RW-1:0] rem_a [0:NW];
  logic [NW-1:0] num_a [0:NW];
  logic [AW-1:0] quo_a [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d[0] <= 1'b0;
    end else if (advance) begin
      v_d[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oor_d[0] <= in_oor;
      rem_p[0] <= '0;
      num_p[0] <= {2'b00, in_stack, 24'd0, stack_count};
      quo_p[0] <= '0;
      rem_a[0] <= '0;
      num_a[0] <= {1'b0, in_slice, 25'd0, slice_count};
      quo_a[0] <= '0;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_div
    logic [RW:0]   sh_p;
    logic [RW:0]   sh_a;
    logic          ge_p;
    logic          ge_a;
    logic [RW:0]   df_p;
    logic [RW:0]   df_a;

    assign sh_p = {rem_p[i], num_p[i][NW-1]};
    assign sh_a = {rem_a[i], num_a[i][NW-1]};
    assign ge_p = sh_p >= {1'b0, dvs_pol};
    assign ge_a = sh_a >= {1'b0, dvs_az};
    assign df_p = sh_p - {1'b0, dvs_pol};
    assign df_a = sh_a - {1'b0, dvs_az};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[i+1] <= 1'b0;
      end else if (advance) begin
        v_d[i+1] <= v_d[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        oor_d[i+1] <= oor_d[i];
        rem_p[i+1] <= ge_p ? df_p[RW-1:0] : sh_p[RW-1:0];
        rem_a[i+1] <= ge_a ? df_a[RW-1:0] : sh_a[RW-1:0];
        num_p[i+1] <= {num_p[i][NW-2:0], 1'b0};
        num_a[i+1] <= {num_a[i][NW-2:0], 1'b0};
        quo_p[i+1] <= {quo_p[i][AW-2:0], ge_p};
        quo_a[i+1] <= {quo_a[i][AW-2:0], ge_a};
      end
    end
  end

  // CORDIC rotation pipeline
  logic                    v_c   [0:RS];
  logic                    oor_c [0:RS];
  logic signed [CW-1:0]    xp    [0:RS];
  logic signed [CW-1:0]    yp    [0:RS];
  logic signed [ZW-1:0]    zp    [0:RS];
  logic [1:0]              qp    [0:RS];
  logic signed [CW-1:0]    xa    [0:RS];
  logic signed [CW-1:0]    ya    [0:RS];
  logic signed [ZW-1:0]    za    [0:RS];
  logic [1:0]              qa    [0:RS];

  assign v_c[0]   = v_d[NW];
  assign oor_c[0] = oor_d[NW];
  assign xp[0]    = usvg_pkg::ROT_GAIN_INV;
  assign yp[0]    = '0;
  assign zp[0]    = {2'b00, quo_p[NW][AW-3:0]};
  assign qp[0]    = quo_p[NW][AW-1:AW-2];
  assign xa[0]    = usvg_pkg::ROT_GAIN_INV;
  assign ya[0]    = '0;
  assign za[0]    = {2'b00, quo_a[NW][AW-3:0]};
  assign qa[0]    = quo_a[NW][AW-1:AW-2];

  for (genvar k = 0; k < RS; k++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = usvg_pkg::atan_turn(k);
    logic signed [CW-1:0] dxp;
    logic signed [CW-1:0] dyp;
    logic signed [CW-1:0] dxa;
    logic signed [CW-1:0] dya;

    assign dxp = yp[k] >>> k;
    assign dyp = xp[k] >>> k;
    assign dxa = ya[k] >>> k;
    assign dya = xa[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_c[k+1] <= 1'b0;
      end else if (advance) begin
        v_c[k+1] <= v_c[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        oor_c[k+1] <= oor_c[k];
        qp[k+1]    <= qp[k];
        qa[k+1]    <= qa[k];
        if (!zp[k][ZW-1]) begin
          xp[k+1] <= xp[k] - dxp;
          yp[k+1] <= yp[k] + dyp;
          zp[k+1] <= zp[k] - AT;
        end else begin
          xp[k+1] <= xp[k] + dxp;
          yp[k+1] <= yp[k] - dyp;
          zp[k+1] <= zp[k] + AT;
        end
        if (!za[k][ZW-1]) begin
          xa[k+1] <= xa[k] - dxa;
          ya[k+1] <= ya[k] + dya;
          za[k+1] <= za[k] - AT;
        end else begin
          xa[k+1] <= xa[k] + dxa;
          ya[k+1] <= ya[k] - dya;
          za[k+1] <= za[k] + AT;
        end
      end
    end
  end

  // quadrant stage
  logic                 v_q;
  logic                 oor_q;
  logic signed [CW-1:0] cp;
  logic signed [CW-1:0] sp;
  logic signed [CW-1:0] ca;
  logic signed [CW-1:0] sa;
  logic signed [CW-1:0] cp_next;
  logic signed [CW-1:0] sp_next;
  logic signed [CW-1:0] ca_next;
  logic signed [CW-1:0] sa_next;

  always_comb begin
    unique case (qp[RS])
      2'd0: begin cp_next = xp[RS];  sp_next = yp[RS];  end
      2'd1: begin cp_next = -yp[RS]; sp_next = xp[RS];  end
      2'd2: begin cp_next = -xp[RS]; sp_next = -yp[RS]; end
      default: begin cp_next = yp[RS]; sp_next = -xp[RS]; end
    endcase
    unique case (qa[RS])
      2'd0: begin ca_next = xa[RS];  sa_next = ya[RS];  end
      2'd1: begin ca_next = -ya[RS]; sa_next = xa[RS];  end
      2'd2: begin ca_next = -xa[RS]; sa_next = -ya[RS]; end
      default: begin ca_next = ya[RS]; sa_next = -xa[RS]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else if (advance) begin
      v_q <= v_c[RS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oor_q <= oor_c[RS];
      cp    <= cp_next;
      sp    <= sp_next;
      ca    <= ca_next;
      sa    <= sa_next;
    end
  end

  // multiply stage
  logic                 v_m;
  logic                 oor_m;
  logic signed [PW-1:0] prod_x;
  logic signed [PW-1:0] prod_z;
  logic signed [CW-1:0] cp_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (advance) begin
      v_m <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oor_m  <= oor_q;
      prod_x <= ca * sp;
      prod_z <= sa * sp;
      cp_m   <= cp;
    end
  end

  // rounding, saturation and output register
  localparam logic signed [PW-1:0] HALF_XZ = PW'(1) <<< (SH_XZ - 1);
  localparam logic signed [CW:0]   HALF_Y  = (CW+1)'(1) <<< (SH_Y - 1);
  localparam logic signed [PW-1:0] LIM_XZ  = PW'(1) <<< FB;
  localparam logic signed [CW:0]   LIM_Y   = (CW+1)'(1) <<< FB;

  logic signed [PW-1:0] rx;
  logic signed [PW-1:0] rz;
  logic signed [CW:0]   ry;
  logic [usvg_pkg::OUT_W-1:0] pos_x_next;
  logic [usvg_pkg::OUT_W-1:0] pos_y_next;
  logic [usvg_pkg::OUT_W-1:0] pos_z_next;

  always_comb begin
    rx = (prod_x + HALF_XZ) >>> SH_XZ;
    rz = (prod_z + HALF_XZ) >>> SH_XZ;
    ry = ($signed({cp_m[CW-1], cp_m}) + HALF_Y) >>> SH_Y;
    priority if (rx > LIM_XZ) rx = LIM_XZ;
    else if (rx < -LIM_XZ) rx = -LIM_XZ;
    else rx = rx;
    priority if (rz > LIM_XZ) rz = LIM_XZ;
    else if (rz < -LIM_XZ) rz = -LIM_XZ;
    else rz = rz;
    priority if (ry > LIM_Y) ry = LIM_Y;
    else if (ry < -LIM_Y) ry = -LIM_Y;
    else ry = ry;
    pos_x_next = oor_m ? '0 : rx[usvg_pkg::OUT_W-1:0];
    pos_y_next = oor_m ? '0 : ry[usvg_pkg::OUT_W-1:0];
    pos_z_next = oor_m ? '0 : rz[usvg_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {pos_z_next, pos_y_next, pos_x_next};
      m_tuser <= oor_m;
    end
  end

endmodule

[test/uv_sphere_vertex_generator_core_test.sv]
// Self-checking testbench for the UV sphere vertex generator core.
module uv_sphere_vertex_generator_core_test;

  localparam int LATENCY   = 76;
  localparam int CYCLE_CAP = 1000000;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic        out_of_range;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [usvg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [usvg_pkg::CNT_W-1:0] cfg_data = '0;

  uv_sphere_vertex_generator_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] stacks;
  logic [7:0] slices;
  vertex_t vertex_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [15:0] round_coord(longint v, int s);
    longint r;
    longint lim;
    lim = longint'(1) << usvg_pkg::COORD_FRAC_BITS;
    r = floor_shift(v + (longint'(1) << (s - 1)), s);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint at;
    x = 64'h26DD3B6A;
    y = 0;
    z = ang[29:0];
    for (int k = 0; k < usvg_pkg::ROT_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      at = longint'(usvg_pkg::atan_turn(k));
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    case (ang[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_vertex(input logic [7:0] si, input logic [7:0] sj);
    vertex_t v;
    logic [63:0] num;
    logic [31:0] polar;
    logic [31:0] azim;
    longint cp, sp, ca, sa;
    v = '0;
    if (stacks == 0 || slices == 0 || si > stacks || sj > slices) begin
      v.out_of_range = 1'b1;
    end else begin
      num = ({56'd0, si} << 32) + stacks;
      polar = 32'(num / (2 * 64'(stacks)));
      num = ({56'd0, sj} << 33) + slices;
      azim = 32'(num / (2 * 64'(slices)));
      rotate(polar, cp, sp);
      rotate(azim, ca, sa);
      v.pos_x = round_coord(ca * sp, 60 - usvg_pkg::COORD_FRAC_BITS);
      v.pos_y = round_coord(cp, 30 - usvg_pkg::COORD_FRAC_BITS);
      v.pos_z = round_coord(sa * sp, 60 - usvg_pkg::COORD_FRAC_BITS);
    end
    vertex_q = {vertex_q, v};
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: stall pattern, long hold-off and result check
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    vertex_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        $error("result with no vertex expected");
        errors++;
      end else begin
        want = vertex_q.pop_front();
        if (m_tdata[15:0] !== want.pos_x) begin
          $error("pos_x expected %h got %h", want.pos_x, m_tdata[15:0]); errors++;
        end
        if (m_tdata[31:16] !== want.pos_y) begin
          $error("pos_y expected %h got %h", want.pos_y, m_tdata[31:16]); errors++;
        end
        if (m_tdata[47:32] !== want.pos_z) begin
          $error("pos_z expected %h got %h", want.pos_z, m_tdata[47:32]); errors++;
        end
        if (m_tuser[0] !== want.out_of_range) begin
          $error("out_of_range expected %b got %b", want.out_of_range, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  task automatic send_point(input logic [7:0] si, input logic [7:0] sj);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {sj, si};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertex(si, sj);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain;
    while (vertex_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic [usvg_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == usvg_pkg::CFG_STACK_COUNT) stacks = val;
    else if (idx == usvg_pkg::CFG_SLICE_COUNT) slices = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_counts(input logic [7:0] st, input logic [7:0] sl);
    drain();
    write_reg(usvg_pkg::CFG_STACK_COUNT, st);
    write_reg(usvg_pkg::CFG_SLICE_COUNT, sl);
  endtask

  task automatic test_directed;
    send_point(0, 0);
    send_point(16, 16);
    send_point(8, 4);
    send_point(17, 0);
    send_point(0, 17);
    send_point(255, 255);
    send_point(8'hAA, 8'h55);
    set_counts(255, 255);
    send_point(255, 255);
    send_point(128, 64);
    send_point(1, 254);
    send_point(8'h55, 8'hAA);
    set_counts(1, 1);
    send_point(0, 1);
    send_point(1, 0);
    send_point(2, 1);
    set_counts(0, 5);
    send_point(0, 0);
    set_counts(5, 0);
    send_point(0, 0);
    drain();
    // unknown register index must be ignored
    write_reg(8'd2, 8'd3);
    write_reg(8'hFF, 8'd9);
    set_counts(3, 7);
    send_point(3, 7);
    send_point(2, 5);
  endtask

  task automatic random_points(input int n);
    logic [7:0] si;
    logic [7:0] sj;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        si = 8'($urandom_range(255));
        sj = 8'($urandom_range(255));
      end else begin
        si = 8'($urandom_range(stacks));
        sj = 8'($urandom_range(slices));
      end
      send_point(si, sj);
    end
  endtask

  task automatic test_random;
    int mode;
    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 1) ? 85 : 35) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 85 : 35) : 0;
      if (ph == 4) set_counts(255, 1);
      else if (ph == 6) set_counts(2, 255);
      else set_counts(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
      random_points(150);
    end
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_counts(12, 24);
    hold_cycles = 300;
    random_points(100);
    drain();
    random_points(20);
  endtask

  initial begin
    stacks = usvg_pkg::STACK_COUNT_RST;
    slices = usvg_pkg::SLICE_COUNT_RST;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random();
    test_backpressure();
    drain();
    if (errors == 0 && vertex_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
